### rtl/dfe_pkg.sv
// Package for the DLE frame encoder: slot layout of one item's byte plan,
// register indexes, command codes and reset values. No dependencies.
`timescale 1ns / 1ps

package dfe_pkg;

  localparam int unsigned NSLOT  = 8;
  localparam int unsigned SLOT_W = $clog2(NSLOT);

  // Command codes carried in the input tuser bit.
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  // Configuration register indexes.
  localparam logic REG_ESCAPE = 1'b0;
  localparam logic REG_END    = 1'b1;

  localparam logic [7:0] ESCAPE_RESET = 8'd16;
  localparam logic [7:0] END_RESET    = 8'd3;
  localparam logic [7:0] CHK_BASE     = 8'hFF;

  // Fixed slot positions of the byte plan, in emission order.
  localparam logic [SLOT_W-1:0] SLOT_HEAD_ESC = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_ID_HI    = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_ID_LO    = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_LEN_HI   = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_LEN_LO   = 3'd4;
  localparam logic [SLOT_W-1:0] SLOT_CHK      = 3'd5;
  localparam logic [SLOT_W-1:0] SLOT_TAIL_ESC = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_END      = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       dbl;     // byte equals escape, send it twice
    logic       done;    // closing end-of-text byte
    logic       misuse;  // payload arrived with no open frame
  } slot_t;

  typedef struct packed {
    slot_t [NSLOT-1:0] slot;
    logic  [NSLOT-1:0] en;
  } plan_t;

endpackage

### rtl/dfe_frame_ctl.sv
// Frame state and configuration registers of the DLE frame encoder; builds the
// byte plan of each accepted word. Depends on dfe_pkg.
`timescale 1ns / 1ps

module dfe_frame_ctl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_wdata,
  input  logic          accept,
  input  logic          cmd,
  input  logic [15:0]   packet_id,
  input  logic [15:0]   frame_length,
  input  logic [7:0]    payload_byte,
  output dfe_pkg::plan_t plan
);
  import dfe_pkg::*;

  logic [7:0]  escape_r, end_r;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic        open_r, open_nxt;

  logic [7:0]  hdr_sum, pay_sum, chk;
  logic        trailer;

  assign hdr_sum = packet_id[15:8] + packet_id[7:0] + frame_length[15:8] + frame_length[7:0];
  assign pay_sum = running_sum_r + payload_byte;

  always_comb begin
    plan            = '0;
    running_sum_nxt = running_sum_r;
    remaining_nxt   = remaining_r;
    open_nxt        = open_r;
    trailer         = 1'b0;
    chk             = CHK_BASE - hdr_sum;
    unique case (cmd)
      CMD_START: begin
        running_sum_nxt = hdr_sum;
        remaining_nxt   = frame_length;
        trailer         = (frame_length == 16'd0);
        open_nxt        = !trailer;
        plan.en[SLOT_HEAD_ESC]        = 1'b1;
        plan.slot[SLOT_HEAD_ESC].data = escape_r;
        plan.en[SLOT_ID_HI]           = 1'b1;
        plan.slot[SLOT_ID_HI].data    = packet_id[15:8];
        plan.en[SLOT_ID_LO]           = 1'b1;
        plan.slot[SLOT_ID_LO].data    = packet_id[7:0];
        plan.en[SLOT_LEN_HI]          = 1'b1;
        plan.slot[SLOT_LEN_HI].data   = frame_length[15:8];
        plan.en[SLOT_LEN_LO]          = 1'b1;
        plan.slot[SLOT_LEN_LO].data   = frame_length[7:0];
        plan.slot[SLOT_ID_HI].dbl     = (packet_id[15:8] == escape_r);
        plan.slot[SLOT_ID_LO].dbl     = (packet_id[7:0] == escape_r);
        plan.slot[SLOT_LEN_HI].dbl    = (frame_length[15:8] == escape_r);
        plan.slot[SLOT_LEN_LO].dbl    = (frame_length[7:0] == escape_r);
      end
      CMD_PAYLOAD: begin
        if (open_r) begin
          chk             = CHK_BASE - pay_sum;
          running_sum_nxt = pay_sum;
          remaining_nxt   = remaining_r - 16'd1;
          trailer         = (remaining_r == 16'd1);
          open_nxt        = !trailer;
          plan.en[SLOT_ID_HI]        = 1'b1;
          plan.slot[SLOT_ID_HI].data = payload_byte;
          plan.slot[SLOT_ID_HI].dbl  = (payload_byte == escape_r);
        end else begin
          // The byte is dropped; a single flagged zero byte reports it.
          plan.en[SLOT_HEAD_ESC]          = 1'b1;
          plan.slot[SLOT_HEAD_ESC].misuse = 1'b1;
        end
      end
      default: ;
    endcase
    if (trailer) begin
      plan.en[SLOT_CHK]             = 1'b1;
      plan.slot[SLOT_CHK].data      = chk;
      plan.slot[SLOT_CHK].dbl       = (chk == escape_r);
      plan.en[SLOT_TAIL_ESC]        = 1'b1;
      plan.slot[SLOT_TAIL_ESC].data = escape_r;
      plan.en[SLOT_END]             = 1'b1;
      plan.slot[SLOT_END].data      = end_r;
      plan.slot[SLOT_END].done      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_r      <= ESCAPE_RESET;
      end_r         <= END_RESET;
      running_sum_r <= '0;
      remaining_r   <= '0;
      open_r        <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_ESCAPE) escape_r <= cfg_wdata;
      if (cfg_we && cfg_index == REG_END)    end_r    <= cfg_wdata;
      if (accept) begin
        running_sum_r <= running_sum_nxt;
        remaining_r   <= remaining_nxt;
        open_r        <= open_nxt;
      end
    end
  end

endmodule

### rtl/dfe_byte_emit.sv
// Byte sequencer of the DLE frame encoder: holds one word's plan and sends its
// bytes, one per cycle unless the output stalls, through the output register. Depends on dfe_pkg.
`timescale 1ns / 1ps

module dfe_byte_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  dfe_pkg::plan_t plan,
  output logic           ready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast,
  output logic [1:0]     out_tuser
);
  import dfe_pkg::*;

  plan_t             plan_r;
  logic [NSLOT-1:0]  mask_r, mask_nxt, mask_left;
  logic              dup_r, dup_nxt;
  logic              valid_r, valid_nxt;
  logic [7:0]        data_r;
  logic              last_r, done_r, misuse_r;
  logic [SLOT_W-1:0] cur_idx;
  slot_t             cur;
  logic              busy, fire, slot_end, item_end;

  always_comb begin
    cur_idx = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (mask_r[i]) cur_idx = SLOT_W'(i);
    end
  end

  assign cur       = plan_r.slot[cur_idx];
  assign busy      = |mask_r;
  assign fire      = busy && (!valid_r || out_tready);
  assign slot_end  = !(cur.dbl && !dup_r);
  assign mask_left = mask_r & ~(NSLOT'(1) << cur_idx);
  assign item_end  = slot_end && (mask_left == '0);
  assign ready     = !busy || (fire && item_end);

  always_comb begin
    mask_nxt  = mask_r;
    dup_nxt   = dup_r;
    valid_nxt = valid_r;
    if (fire) begin
      valid_nxt = 1'b1;
      dup_nxt   = !slot_end;
      if (slot_end) mask_nxt = mask_left;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      mask_nxt = plan.en;
      dup_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      dup_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      mask_r  <= mask_nxt;
      dup_r   <= dup_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) plan_r <= plan;
    if (fire) begin
      data_r   <= cur.data;
      last_r   <= item_end;
      done_r   <= cur.done;
      misuse_r <= cur.misuse;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = {misuse_r, done_r};

endmodule

### rtl/dle_frame_encoder.sv
// DLE frame encoder: an accepted word passes into a byte plan register and its
// bytes leave one per cycle, unless the receiver stalls, through the output register.
// A word emits 1 to 12 bytes, all through the single output byte lane; the next
// word is taken in the cycle its predecessor's last byte issues.
// Reset (rst_n low, synchronous) closes any frame, clears the sum and the count,
// empties the output and restores escape 16 and end-of-text 3.
`timescale 1ns / 1ps

module dle_frame_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // packet_id[15:0], frame_length[31:16], payload_byte[39:32]
  input  logic        in_tuser,   // cmd: 0 start frame, 1 payload byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tlast,  // last byte caused by the input word
  output logic [1:0]  out_tuser   // frame_done[0], misuse[1]
);
  import dfe_pkg::*;

  plan_t plan;
  logic  accept;

  // A word is accepted whenever the sequencer has no plan left or is sending
  // the final byte of the current plan in this cycle.
  assign accept = in_tvalid && in_tready;

  // The controller owns the frame state and builds the plan: every header,
  // payload and trailer byte sits in a fixed slot with its doubling flag.
  dfe_frame_ctl u_ctl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .accept       (accept),
    .cmd          (in_tuser),
    .packet_id    (in_tdata[15:0]),
    .frame_length (in_tdata[31:16]),
    .payload_byte (in_tdata[39:32]),
    .plan         (plan)
  );

  // The sequencer walks the enabled slots in order and repeats doubled ones.
  dfe_byte_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .plan       (plan),
    .ready      (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### rtl/dfe_checker.sv
// Port-level checks for the DLE frame encoder, bound to its top level.
// Depends on dle_frame_encoder only through its ports.
`timescale 1ns / 1ps

module dfe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast,
  input logic [1:0]  out_tuser
);

  // A stalled output word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // The end-of-text byte always closes the run of its input word.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("frame end not marked last");

  // A misuse report is a lone zero byte and never ends a frame.
  a_misuse_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && out_tdata == 8'd0 && !out_tuser[0])
    else $error("malformed misuse report");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind dle_frame_encoder dfe_checker u_dfe_checker (.*);

### tb/dle_frame_encoder_chk.sv
// Checker for the DLE frame encoder: watches the register port and both streams,
// predicts every output byte and compares it field by field. Needs dfe_pkg.
`timescale 1ns / 1ps

module dle_frame_encoder_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // packet_id[15:0], frame_length[31:16], payload_byte[39:32]
  input  logic        in_tuser,   // cmd
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // out_byte[7:0]
  input  logic        out_tlast,
  input  logic [1:0]  out_tuser,  // frame_done[0], misuse[1]
  output int          mismatch_count,
  output int          pending
);
  import dfe_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       misuse;
  } enc_byte_t;

  enc_byte_t  frame_bytes[$];
  logic [7:0] esc_val;
  logic [7:0] end_val;
  logic [7:0] frame_sum;
  logic [15:0] bytes_left;
  logic       in_frame;
  int         errors;

  function automatic void emit(input logic [7:0] b, input logic done, input logic misuse);
    enc_byte_t e;
    e.data   = b;
    e.last   = 1'b0;
    e.done   = done;
    e.misuse = misuse;
    frame_bytes.push_back(e);
  endfunction

  function automatic void emit_stuffed(input logic [7:0] b);
    emit(b, 1'b0, 1'b0);
    if (b == esc_val) emit(esc_val, 1'b0, 1'b0);
  endfunction

  function automatic void emit_summed(input logic [7:0] b);
    frame_sum = frame_sum + b;
    emit_stuffed(b);
  endfunction

  function automatic void emit_trailer();
    emit_stuffed(CHK_BASE - frame_sum);
    emit(esc_val, 1'b0, 1'b0);
    emit(end_val, 1'b1, 1'b0);
    in_frame = 1'b0;
  endfunction

  // Expected bytes for one accepted input word; the final one carries tlast.
  function automatic void encode_word(input logic cmd, input logic [15:0] id,
                                      input logic [15:0] len, input logic [7:0] pb);
    enc_byte_t tail;
    if (cmd == CMD_START) begin
      frame_sum  = 8'h00;
      in_frame   = 1'b1;
      bytes_left = len;
      emit(esc_val, 1'b0, 1'b0);
      emit_summed(id[15:8]);
      emit_summed(id[7:0]);
      emit_summed(len[15:8]);
      emit_summed(len[7:0]);
      if (len == 16'd0) emit_trailer();
    end else if (!in_frame) begin
      emit(8'h00, 1'b0, 1'b1);
    end else begin
      emit_summed(pb);
      bytes_left = bytes_left - 16'd1;
      if (bytes_left == 16'd0) emit_trailer();
    end
    tail = frame_bytes.pop_back();
    tail.last = 1'b1;
    frame_bytes.push_back(tail);
  endfunction

  always @(posedge clk) begin
    enc_byte_t want;
    enc_byte_t got;
    if (!rst_n) begin
      esc_val    = ESCAPE_RESET;
      end_val    = END_RESET;
      frame_sum  = 8'h00;
      bytes_left = 16'd0;
      in_frame   = 1'b0;
      errors     = 0;
      frame_bytes.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ESCAPE) esc_val = cfg_wdata;
        else end_val = cfg_wdata;
      end
      if (in_tvalid && in_tready)
        encode_word(in_tuser, in_tdata[15:0], in_tdata[31:16], in_tdata[39:32]);
      if (out_tvalid && out_tready) begin
        got.data   = out_tdata;
        got.last   = out_tlast;
        got.done   = out_tuser[0];
        got.misuse = out_tuser[1];
        if (frame_bytes.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected output byte %02h last %b done %b misuse %b",
                     $realtime, got.data, got.last, got.done, got.misuse);
        end else begin
          want = frame_bytes.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("%0t: byte mismatch: expected %02h/%b/%b/%b, got %02h/%b/%b/%b",
                       $realtime, want.data, want.last, want.done, want.misuse,
                       got.data, got.last, got.done, got.misuse);
          end
        end
      end
    end
    mismatch_count <= errors;
    pending        <= frame_bytes.size();
  end

endmodule

### tb/dle_frame_encoder_tb.sv
// Top of the DLE frame encoder testbench: clock, reset, register writes, input
// words and output back-pressure, plus the verdict. Needs dfe_pkg and the checker.
`timescale 1ns / 1ps

module dle_frame_encoder_tb;
  import dfe_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [7:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;

  int          mismatch_count;
  int          pending;

  // Escape value currently loaded, so random bytes can be steered onto it.
  logic [7:0]  esc_cur;
  // When clear, neither side inserts random idle cycles; the one long hold still applies.
  bit          idle_on;
  // Raised once to make the receiver hold off for a long stretch.
  logic        pressure_go;
  int          words_sent;

  dle_frame_encoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  dle_frame_encoder_chk frame_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Idle lengths: mostly none or a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // A quarter of the random bytes hit the escape value so stuffing is busy.
  function automatic logic [7:0] pick8();
    if ($urandom_range(0, 3) == 0) return esc_cur;
    return 8'($urandom);
  endfunction

  // The receiver runs on its own. Each cycle it either continues a stall or
  // decides afresh; the one long hold is counted here, so the sender keeps
  // pushing words while the block backs up and drops in_tready.
  initial begin
    int  stall;
    bit  long_done;
    stall      = 0;
    long_done  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_go && !long_done) begin
        long_done = 1'b1;
        stall     = 300;
      end else if (stall == 0 && idle_on && $urandom_range(0, 99) < 20) begin
        stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 30);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one word and hold it until the block takes it. An optional idle
  // gap comes first, so in_tvalid is only ever assigned once per edge.
  task automatic send_word(input logic cmd, input logic [15:0] id,
                           input logic [15:0] len, input logic [7:0] pb);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {pb, len, id};
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // One start word and its payload. A broken frame stops short, so the next
  // start abandons it; unused fields carry random junk.
  task automatic send_frame(input int max_len, input bit broken);
    logic [15:0] len;
    int          stop;
    len = 16'($urandom_range(0, max_len));
    send_word(CMD_START, {pick8(), pick8()}, len, 8'($urandom));
    if (!broken) stop = int'(len);
    else if (len == 16'd0) stop = 0;
    else stop = $urandom_range(0, (len > 16'd4) ? 4 : int'(len) - 1);
    for (int i = 0; i < stop; i++)
      send_word(CMD_PAYLOAD, 16'($urandom), 16'($urandom), pick8());
  endtask

  // Wait until every predicted byte has come out. The first edge is always
  // taken, so a word accepted at the current edge has been counted.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Both registers are written back to back; only done while the block idles.
  task automatic load_chars(input logic [7:0] esc, input logic [7:0] endc);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ESCAPE;
    cfg_wdata <= esc;
    @(posedge clk);
    cfg_index <= REG_END;
    cfg_wdata <= endc;
    @(posedge clk);
    cfg_we    <= 1'b0;
    esc_cur = esc;
  endtask

  initial begin
    int         target;
    int         kind;
    logic [7:0] c;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_ESCAPE;
    cfg_wdata   = 8'h00;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_START;
    pressure_go = 1'b0;
    idle_on     = 1'b1;
    words_sent  = 0;
    esc_cur     = ESCAPE_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset values of escape and end-of-text.
    // A payload with no frame open is flagged and dropped.
    send_word(CMD_PAYLOAD, 16'h0000, 16'h0000, 8'hFF);
    // Both id bytes equal escape; a zero length closes the frame at once.
    send_word(CMD_START, 16'h1010, 16'h0000, 8'h00);
    // Header sum 0xEF makes the checksum equal escape, so it is doubled.
    send_word(CMD_START, 16'h00EF, 16'h0000, 8'h00);
    // Full frame with an escaped payload byte and the byte extremes.
    send_word(CMD_START, 16'hFFFF, 16'h0003, 8'h00);
    send_word(CMD_PAYLOAD, 16'h0000, 16'h0000, 8'h10);
    send_word(CMD_PAYLOAD, 16'hFFFF, 16'hFFFF, 8'h00);
    send_word(CMD_PAYLOAD, 16'h0000, 16'h0000, 8'hFF);
    // Length bytes equal escape; this frame is abandoned by the next start.
    send_word(CMD_START, 16'hABCD, 16'h1010, 8'h00);
    send_word(CMD_PAYLOAD, 16'h0000, 16'h0000, 8'h55);
    // A payload byte equal to escape that also lands the checksum on escape:
    // the word produces its largest output of six bytes.
    send_word(CMD_START, 16'h00DE, 16'h0001, 8'h00);
    send_word(CMD_PAYLOAD, 16'h0000, 16'h0000, 8'h10);
    send_word(CMD_PAYLOAD, 16'h0000, 16'h0000, 8'h42);
    // Largest length, left open across the register change below.
    send_word(CMD_START, 16'h0000, 16'hFFFF, 8'hFF);
    send_word(CMD_PAYLOAD, 16'h0000, 16'h0000, 8'h00);
    send_word(CMD_PAYLOAD, 16'h0000, 16'h0000, 8'hFF);
    drain();

    // Escape zero with end-of-text equal to it: an all-zero header doubles
    // every header byte, twelve output bytes from one word, and the end byte
    // must still go out only once.
    load_chars(8'h00, 8'h00);
    send_word(CMD_START, 16'h0000, 16'h0000, 8'h00);
    send_word(CMD_START, 16'h0000, 16'h0001, 8'h00);
    send_word(CMD_PAYLOAD, 16'h0000, 16'h0000, 8'h00);
    drain();

    // Top-of-range register values.
    load_chars(8'hFF, 8'hFF);
    send_word(CMD_START, 16'hFFFF, 16'h00FF, 8'h00);
    send_word(CMD_START, 16'hFFFF, 16'h0000, 8'h00);
    send_word(CMD_PAYLOAD, 16'h0000, 16'h0000, 8'h7E);
    drain();

    // Back-pressure: the receiver holds off for a long stretch while the
    // sender streams short frames with no gaps, so the input must stall.
    load_chars(8'h7E, 8'h7D);
    idle_on = 1'b0;
    pressure_go <= 1'b1;
    target = words_sent + 24;
    while (words_sent < target) send_frame(4, 1'b0);
    drain();

    // Random phases over several register settings, one with no idling.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_chars(8'($urandom), 8'($urandom));
        1: load_chars(8'h00, 8'hFF);
        2: load_chars(8'hFF, 8'h00);
        3: begin
          c = 8'($urandom);
          load_chars(c, c);
        end
        default: load_chars(ESCAPE_RESET, END_RESET);
      endcase
      idle_on = (ph != 2);
      target = words_sent + 18;
      while (words_sent < target) begin
        kind = $urandom_range(0, 99);
        // Mostly well-formed frames; the rest are stray payload words,
        // frames cut short, and huge lengths that are never finished.
        if (kind < 72) send_frame(($urandom_range(0, 9) == 0) ? 24 : 6, 1'b0);
        else if (kind < 82) send_word(CMD_PAYLOAD, 16'($urandom), 16'($urandom), pick8());
        else if (kind < 94) send_frame(6, 1'b1);
        else send_frame(65535, 1'b1);
      end
      drain();
    end

    // Let any stray output surface before the verdict.
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
